// ===== sv/lpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpc_pkg;

	localparam int PT_W     = 32;   // point coordinate, Q16.16
	localparam int OUT_W    = 48;   // covariance entry, Q16.32
	localparam int RE_W     = 16;   // range_error, Q0.16
	localparam int AV_W     = 48;   // angle_variance, Q0.48
	localparam int DATA_W   = 64;
	localparam int ADDR_W   = 4;
	localparam int NENT     = 6;    // xx xy xz yy yz zz
	localparam int NAX      = 3;
	localparam int Q_W      = 32;   // range term quotient bits
	localparam int SQ_W     = 64;   // squares, r2, products of coordinates
	localparam int N_W      = 96;   // range term numerator
	localparam int B_W      = 112;  // full bearing product
	localparam int BT_W     = 51;   // clamped bearing term
	localparam int SUM_W    = 53;
	localparam int DIV_STAGES = Q_W;

	localparam int REG_SEL_BIT = ADDR_W - 1;
	localparam logic REG_RANGE_ERROR    = 1'b0;
	localparam logic REG_ANGLE_VARIANCE = 1'b1;

	localparam logic [RE_W-1:0] RANGE_ERROR_RST    = 16'd328;
	localparam logic [AV_W-1:0] ANGLE_VARIANCE_RST = 48'd34296800;

	// 0.0001 m in Q16.16
	localparam logic [PT_W-1:0] ZERO_Z_SUBST = 32'd7;
	localparam logic [BT_W-1:0] BEARING_CLAMP = {1'b1, {(BT_W-1){1'b0}}};
	localparam logic [B_W-1:0]  BEARING_HALF  = B_W'(1) << 47;

	localparam longint SAT_MAX_L = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint SAT_MIN_L = -(longint'(1) <<< (OUT_W - 1));
	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(SAT_MAX_L);
	localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(SAT_MIN_L);

	typedef struct packed {
		logic [NENT-1:0][SQ_W-1:0] rem;
		logic [NENT-1:0][Q_W-1:0]  qn;   // numerator low bits in, quotient bits out
		logic [NENT-1:0][BT_W-1:0] bt;
		logic [SQ_W-1:0]           r2;
		logic [NENT-1:0]           neg;
	} div_t;

	function automatic logic [1:0] row_of(int e);
		logic [1:0] r;
		case (e)
			0, 1, 2: r = 2'd0;
			3, 4:    r = 2'd1;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] col_of(int e);
		logic [1:0] c;
		case (e)
			0:       c = 2'd0;
			1, 3:    c = 2'd1;
			default: c = 2'd2;
		endcase
		return c;
	endfunction

	function automatic logic is_diag(int e);
		return row_of(e) == col_of(e);
	endfunction

	// one restoring division step on every entry
	function automatic div_t div_step(div_t d);
		div_t o;
		logic [SQ_W:0] t;
		o = d;
		for (int e = 0; e < NENT; e++) begin
			t = {d.rem[e], d.qn[e][Q_W-1]};
			if (t >= {1'b0, d.r2}) begin
				o.rem[e] = SQ_W'(t - {1'b0, d.r2});
				o.qn[e]  = {d.qn[e][Q_W-2:0], 1'b1};
			end else begin
				o.rem[e] = t[SQ_W-1:0];
				o.qn[e]  = {d.qn[e][Q_W-2:0], 1'b0};
			end
		end
		return o;
	endfunction

	function automatic logic [OUT_W-1:0] cov_finish(logic [Q_W-1:0] q, logic [BT_W-1:0] bt,
			logic neg, logic diag);
		logic signed [SUM_W-1:0] s1;
		logic signed [SUM_W-1:0] s2;
		logic signed [SUM_W-1:0] sum;
		logic [OUT_W-1:0] r;
		s1 = neg ? -$signed(SUM_W'(q)) : $signed(SUM_W'(q));
		// bearing term enters off-diagonal entries with the sign opposite to the range term
		s2 = (diag || neg) ? $signed(SUM_W'(bt)) : -$signed(SUM_W'(bt));
		sum = s1 + s2;
		if (sum > SAT_MAX)
			r = SAT_MAX[OUT_W-1:0];
		else if (sum < SAT_MIN)
			r = SAT_MIN[OUT_W-1:0];
		else
			r = sum[OUT_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/lpc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lpc_point_if;
	logic valid;
	logic ready;
	logic signed [lpc_pkg::PT_W-1:0] point_x;
	logic signed [lpc_pkg::PT_W-1:0] point_y;
	logic signed [lpc_pkg::PT_W-1:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface lpc_cov_if;
	logic valid;
	logic ready;
	logic signed [lpc_pkg::OUT_W-1:0] cov_xx;
	logic signed [lpc_pkg::OUT_W-1:0] cov_xy;
	logic signed [lpc_pkg::OUT_W-1:0] cov_xz;
	logic signed [lpc_pkg::OUT_W-1:0] cov_yy;
	logic signed [lpc_pkg::OUT_W-1:0] cov_yz;
	logic signed [lpc_pkg::OUT_W-1:0] cov_zz;
	modport source (output valid, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz,
		input ready);
	modport sink (input valid, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz,
		output ready);
endinterface

`default_nettype wire

// ===== sv/lidar_point_covariance.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Payload
// point   | in  | point_x, point_y, point_z (Q16.16)
// cov     | out | cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz (Q16.32)
// apb     | in  | range_error @0x0, angle_variance @0x8
//
// One item per cycle unless stalled as below; 6 front stages, 32 divider stages
// (one quotient bit each), one output register.
// Reset clears all stage valid bits and loads the register defaults.
// Each stage moves when empty or when its successor moves, so bubbles close
// up under a stall; the input stalls only once every stage holds an item.
module lidar_point_covariance (
	input  logic                           clk,
	input  logic                           arst_n,
	lpc_point_if.sink                      point,
	lpc_cov_if.source                      cov,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lpc_pkg::ADDR_W-1:0]     paddr,
	input  logic [lpc_pkg::DATA_W-1:0]     pwdata,
	output logic [lpc_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);

	logic [lpc_pkg::RE_W-1:0] range_error_q;
	logic [lpc_pkg::AV_W-1:0] angle_variance_q;

	logic          mid_valid;
	logic          mid_ready;
	lpc_pkg::div_t mid_data;
	logic [lpc_pkg::NENT-1:0][lpc_pkg::OUT_W-1:0] entries;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_error_q    <= lpc_pkg::RANGE_ERROR_RST;
			angle_variance_q <= lpc_pkg::ANGLE_VARIANCE_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[lpc_pkg::REG_SEL_BIT])
				lpc_pkg::REG_RANGE_ERROR:    range_error_q    <= pwdata[lpc_pkg::RE_W-1:0];
				lpc_pkg::REG_ANGLE_VARIANCE: angle_variance_q <= pwdata[lpc_pkg::AV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[lpc_pkg::REG_SEL_BIT])
			lpc_pkg::REG_RANGE_ERROR:    prdata = lpc_pkg::DATA_W'(range_error_q);
			lpc_pkg::REG_ANGLE_VARIANCE: prdata = lpc_pkg::DATA_W'(angle_variance_q);
			default:                     prdata = '0;
		endcase
	end

	lpc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (point.valid),
		.in_ready       (point.ready),
		.point_x        (point.point_x),
		.point_y        (point.point_y),
		.point_z        (point.point_z),
		.range_error    (range_error_q),
		.angle_variance (angle_variance_q),
		.out_valid      (mid_valid),
		.out_ready      (mid_ready),
		.out_data       (mid_data)
	);

	lpc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_data   (mid_data),
		.out_valid (cov.valid),
		.out_ready (cov.ready),
		.entries   (entries)
	);

	assign cov.cov_xx = entries[0];
	assign cov.cov_xy = entries[1];
	assign cov.cov_xz = entries[2];
	assign cov.cov_yy = entries[3];
	assign cov.cov_yz = entries[4];
	assign cov.cov_zz = entries[5];

endmodule

`default_nettype wire

// ===== sv/lpc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Six stages: magnitudes, coordinate products, r2, bearing operands,
// partial products, sums with rounding.
module lpc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [lpc_pkg::PT_W-1:0]   point_x,
	input  logic signed [lpc_pkg::PT_W-1:0]   point_y,
	input  logic signed [lpc_pkg::PT_W-1:0]   point_z,
	input  logic [lpc_pkg::RE_W-1:0]          range_error,
	input  logic [lpc_pkg::AV_W-1:0]          angle_variance,
	output logic                              out_valid,
	input  logic                              out_ready,
	output lpc_pkg::div_t                     out_data
);

	localparam int NST = 6;

	logic [NST-1:0] vld_s;
	logic [NST:0]   adv;

	logic [lpc_pkg::NAX-1:0][lpc_pkg::PT_W-1:0] raw;
	logic [lpc_pkg::NAX-1:0][lpc_pkg::PT_W-1:0] mag_d;
	logic [lpc_pkg::NAX-1:0]                    neg_d;

	logic [lpc_pkg::NAX-1:0][lpc_pkg::PT_W-1:0] mag_s1;
	logic [lpc_pkg::NAX-1:0]                    neg_s1;
	logic [lpc_pkg::Q_W-1:0]                    e2_s1;

	logic [lpc_pkg::NENT-1:0][lpc_pkg::SQ_W-1:0] pp_s2;
	logic [lpc_pkg::NENT-1:0]                    neg_s2;
	logic [lpc_pkg::Q_W-1:0]                     e2_s2;

	logic [lpc_pkg::NENT-1:0][lpc_pkg::SQ_W-1:0] pp_s3;
	logic [lpc_pkg::NENT-1:0]                    neg_s3;
	logic [lpc_pkg::Q_W-1:0]                     e2_s3;
	logic [lpc_pkg::SQ_W-1:0]                    r2_s3;

	logic [lpc_pkg::NENT-1:0][lpc_pkg::SQ_W-1:0] m_s4;
	logic [lpc_pkg::NENT-1:0][lpc_pkg::SQ_W-1:0] p_s4;
	logic [lpc_pkg::NENT-1:0]                    neg_s4;
	logic [lpc_pkg::Q_W-1:0]                     e2_s4;
	logic [lpc_pkg::SQ_W-1:0]                    r2_s4;

	logic [lpc_pkg::NENT-1:0][lpc_pkg::SQ_W-1:0] ral_s5;
	logic [lpc_pkg::NENT-1:0][lpc_pkg::SQ_W-1:0] rah_s5;
	logic [lpc_pkg::NENT-1:0][lpc_pkg::SQ_W-1:0] bll_s5;
	logic [lpc_pkg::NENT-1:0][lpc_pkg::SQ_W-1:0] blh_s5;
	logic [lpc_pkg::NENT-1:0][lpc_pkg::AV_W-1:0] bhl_s5;
	logic [lpc_pkg::NENT-1:0][lpc_pkg::AV_W-1:0] bhh_s5;
	logic [lpc_pkg::NENT-1:0]                    neg_s5;
	logic [lpc_pkg::SQ_W-1:0]                    r2_s5;

	logic [lpc_pkg::NENT-1:0][lpc_pkg::B_W-1:0]  bsum_d;

	logic [lpc_pkg::NENT-1:0][lpc_pkg::N_W-1:0]  n_s6;
	logic [lpc_pkg::NENT-1:0][lpc_pkg::SQ_W-1:0] b_s6;
	logic [lpc_pkg::NENT-1:0]                    neg_s6;
	logic [lpc_pkg::SQ_W-1:0]                    r2_s6;

	// a stage moves when it is empty or its successor moves
	always_comb begin
		adv[NST] = out_ready;
		for (int k = NST - 1; k >= 0; k--)
			adv[k] = !vld_s[k] || adv[k+1];
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0])
				vld_s[0] <= in_valid;
			for (int k = 1; k < NST; k++)
				if (adv[k])
					vld_s[k] <= vld_s[k-1];
		end
	end

	assign raw[0] = point_x;
	assign raw[1] = point_y;
	assign raw[2] = (point_z == '0) ? lpc_pkg::ZERO_Z_SUBST : point_z;

	always_comb begin
		for (int i = 0; i < lpc_pkg::NAX; i++) begin
			neg_d[i] = raw[i][lpc_pkg::PT_W-1];
			mag_d[i] = neg_d[i] ? lpc_pkg::PT_W'(-raw[i]) : raw[i];
		end
	end

	always_comb begin
		for (int e = 0; e < lpc_pkg::NENT; e++)
			bsum_d[e] = lpc_pkg::B_W'(bll_s5[e])
				+ (lpc_pkg::B_W'(blh_s5[e]) << 32)
				+ (lpc_pkg::B_W'(bhl_s5[e]) << 32)
				+ (lpc_pkg::B_W'(bhh_s5[e]) << 64)
				+ lpc_pkg::BEARING_HALF;
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			mag_s1 <= mag_d;
			neg_s1 <= neg_d;
			e2_s1  <= lpc_pkg::Q_W'(range_error) * lpc_pkg::Q_W'(range_error);
		end
		if (adv[1]) begin
			for (int e = 0; e < lpc_pkg::NENT; e++) begin
				pp_s2[e]  <= lpc_pkg::SQ_W'(mag_s1[lpc_pkg::row_of(e)])
					* lpc_pkg::SQ_W'(mag_s1[lpc_pkg::col_of(e)]);
				neg_s2[e] <= neg_s1[lpc_pkg::row_of(e)] ^ neg_s1[lpc_pkg::col_of(e)];
			end
			e2_s2 <= e2_s1;
		end
		if (adv[2]) begin
			pp_s3  <= pp_s2;
			neg_s3 <= neg_s2;
			e2_s3  <= e2_s2;
			r2_s3  <= pp_s2[0] + pp_s2[3] + pp_s2[5];
		end
		if (adv[3]) begin
			// diagonal bearing operand is r2 minus own square
			for (int e = 0; e < lpc_pkg::NENT; e++)
				m_s4[e] <= lpc_pkg::is_diag(e) ? r2_s3 - pp_s3[e] : pp_s3[e];
			p_s4   <= pp_s3;
			neg_s4 <= neg_s3;
			e2_s4  <= e2_s3;
			r2_s4  <= r2_s3;
		end
		if (adv[4]) begin
			for (int e = 0; e < lpc_pkg::NENT; e++) begin
				ral_s5[e] <= lpc_pkg::SQ_W'(e2_s4) * lpc_pkg::SQ_W'(p_s4[e][31:0]);
				rah_s5[e] <= lpc_pkg::SQ_W'(e2_s4) * lpc_pkg::SQ_W'(p_s4[e][63:32]);
				bll_s5[e] <= lpc_pkg::SQ_W'(angle_variance[31:0])
					* lpc_pkg::SQ_W'(m_s4[e][31:0]);
				blh_s5[e] <= lpc_pkg::SQ_W'(angle_variance[31:0])
					* lpc_pkg::SQ_W'(m_s4[e][63:32]);
				bhl_s5[e] <= lpc_pkg::AV_W'(angle_variance[47:32])
					* lpc_pkg::AV_W'(m_s4[e][31:0]);
				bhh_s5[e] <= lpc_pkg::AV_W'(angle_variance[47:32])
					* lpc_pkg::AV_W'(m_s4[e][63:32]);
			end
			neg_s5 <= neg_s4;
			r2_s5  <= r2_s4;
		end
		if (adv[5]) begin
			for (int e = 0; e < lpc_pkg::NENT; e++) begin
				// range numerator with half divisor added for rounding
				n_s6[e] <= lpc_pkg::N_W'(ral_s5[e])
					+ (lpc_pkg::N_W'(rah_s5[e]) << 32)
					+ lpc_pkg::N_W'(r2_s5 >> 1);
				b_s6[e] <= bsum_d[e][lpc_pkg::B_W-1:48];
			end
			neg_s6 <= neg_s5;
			r2_s6  <= r2_s5;
		end
	end

	always_comb begin
		for (int e = 0; e < lpc_pkg::NENT; e++) begin
			out_data.rem[e] = n_s6[e][lpc_pkg::N_W-1:lpc_pkg::Q_W];
			out_data.qn[e]  = n_s6[e][lpc_pkg::Q_W-1:0];
			out_data.bt[e]  = (b_s6[e] > lpc_pkg::SQ_W'(lpc_pkg::BEARING_CLAMP))
				? lpc_pkg::BEARING_CLAMP : b_s6[e][lpc_pkg::BT_W-1:0];
		end
		out_data.r2  = r2_s6;
		out_data.neg = neg_s6;
	end

endmodule

`default_nettype wire

// ===== sv/lpc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bit-per-stage restoring divider for the range term, then sign, sum and
// saturation into the output register.
module lpc_div (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_valid,
	output logic                                         in_ready,
	input  lpc_pkg::div_t                                in_data,
	output logic                                         out_valid,
	input  logic                                         out_ready,
	output logic [lpc_pkg::NENT-1:0][lpc_pkg::OUT_W-1:0] entries
);

	localparam int NST = lpc_pkg::DIV_STAGES;

	lpc_pkg::div_t div_s [NST];
	logic [NST-1:0] vld_s;
	logic [NST:0]   adv;
	logic           out_vld_s;
	logic [lpc_pkg::NENT-1:0][lpc_pkg::OUT_W-1:0] cov_s;

	always_comb begin
		adv[NST] = !out_vld_s || out_ready;
		for (int k = NST - 1; k >= 0; k--)
			adv[k] = !vld_s[k] || adv[k+1];
	end

	assign in_ready  = adv[0];
	assign out_valid = out_vld_s;
	assign entries   = cov_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_s <= 1'b0;
		end else begin
			if (adv[0])
				vld_s[0] <= in_valid;
			for (int k = 1; k < NST; k++)
				if (adv[k])
					vld_s[k] <= vld_s[k-1];
			if (adv[NST])
				out_vld_s <= vld_s[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0])
			div_s[0] <= lpc_pkg::div_step(in_data);
		for (int k = 1; k < NST; k++)
			if (adv[k])
				div_s[k] <= lpc_pkg::div_step(div_s[k-1]);
		if (adv[NST])
			for (int e = 0; e < lpc_pkg::NENT; e++)
				cov_s[e] <= lpc_pkg::cov_finish(div_s[NST-1].qn[e], div_s[NST-1].bt[e],
					div_s[NST-1].neg[e], lpc_pkg::is_diag(e));
	end

endmodule

`default_nettype wire

// ===== sv/lpc_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpc_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [lpc_pkg::OUT_W-1:0]    cov_xx,
	input logic [lpc_pkg::OUT_W-1:0]    cov_xy,
	input logic [lpc_pkg::OUT_W-1:0]    cov_xz,
	input logic [lpc_pkg::OUT_W-1:0]    cov_yy,
	input logic [lpc_pkg::OUT_W-1:0]    cov_yz,
	input logic [lpc_pkg::OUT_W-1:0]    cov_zz
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(cov_xx) && $stable(cov_xy) && $stable(cov_xz)
			&& $stable(cov_yy) && $stable(cov_yz) && $stable(cov_zz))
		else $error("result changed while stalled");

	// variances are sums of non-negative terms
	a_diag_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !cov_xx[lpc_pkg::OUT_W-1] && !cov_yy[lpc_pkg::OUT_W-1]
			&& !cov_zz[lpc_pkg::OUT_W-1])
		else $error("negative variance");

	// with the output slot free every stage can move
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind lidar_point_covariance lpc_check u_lpc_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (point.valid),
	.in_ready  (point.ready),
	.out_valid (cov.valid),
	.out_ready (cov.ready),
	.cov_xx    (cov.cov_xx),
	.cov_xy    (cov.cov_xy),
	.cov_xz    (cov.cov_xz),
	.cov_yy    (cov.cov_yy),
	.cov_yz    (cov.cov_yz),
	.cov_zz    (cov.cov_zz)
);

`default_nettype wire
